// ===== src/zrld_pkg.sv =====
package zrld_pkg;

   // Width of the stream length and byte counter.
   localparam int LENGTH_BITS = 24;

   // Field widths of one result beat.
   localparam int BYTE_BITS  = 8;
   localparam int COUNT_BITS = 15;
   localparam int ERROR_BITS = 2;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COMPRESSED_LENGTH = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PAD_ZERO_BYTES    = 1'd1;

   // Register reset values.
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = LENGTH_BITS'(1);
   localparam logic [BYTE_BITS-1:0]   PAD_RESET    = 8'd7;

   // Result error codes.
   localparam logic [ERROR_BITS-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERROR_BITS-1:0] ERR_TRUNCATED = 2'd1;
   localparam logic [ERROR_BITS-1:0] ERR_OVERRUN   = 2'd2;

   // Extended run offset.
   localparam logic [COUNT_BITS-1:0] EXT_RUN_OFFSET = 15'd129;

   // Queue between the decode front end and the output back end.
   localparam int QUEUE_DEPTH    = 2;
   localparam int QUEUE_PTR_BITS = 1;
   localparam int QUEUE_CNT_BITS = 2;

   // Decode phase.
   typedef enum logic [1:0] {
      PH_HEADER   = 2'd0,
      PH_EXTENDED = 2'd1,
      PH_LITERAL  = 2'd2,
      PH_DONE     = 2'd3
   } phase_type;

   // One queued decode action: a first result and an optional pad result.
   typedef struct packed {
      logic [BYTE_BITS-1:0]  byte_value;
      logic [COUNT_BITS-1:0] repeat_count;
      logic [ERROR_BITS-1:0] error_code;
      logic                  last;
      logic                  pad_follows;
      logic [BYTE_BITS-1:0]  pad_count;
   } entry_type;

endpackage

// ===== src/zrld_front.sv =====
module zrld_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [7:0]                            req_tdata,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [zrld_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [zrld_pkg::LENGTH_BITS-1:0]      csr_data,
   input  logic                                  q_ready,
   output logic                                  q_push,
   output zrld_pkg::entry_type                   q_entry
);

   zrld_pkg::phase_type                 phase_ff, phase_in;
   logic [5:0]                          high_ff, high_in;
   logic [6:0]                          lit_ff, lit_in;
   logic [zrld_pkg::LENGTH_BITS-1:0]    consumed_ff, consumed_in;
   logic [zrld_pkg::LENGTH_BITS-1:0]    length_ff;
   logic [zrld_pkg::BYTE_BITS-1:0]      pad_ff;

   logic                                accept;
   logic                                restart;
   logic [zrld_pkg::LENGTH_BITS-1:0]    pos;
   logic [6:0]                          lit_cnt;
   logic [zrld_pkg::LENGTH_BITS:0]      lit_end;

   assign req_tready = q_ready;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid & q_ready;
   assign restart    = csr_valid & (csr_index == zrld_pkg::CSR_COMPRESSED_LENGTH);

   assign pos     = consumed_ff + zrld_pkg::LENGTH_BITS'(1);
   assign lit_cnt = {1'b0, req_tdata[5:0]} + 7'd1;
   assign lit_end = {1'b0, pos} + (zrld_pkg::LENGTH_BITS + 1)'(lit_cnt);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= zrld_pkg::LENGTH_RESET;
         pad_ff    <= zrld_pkg::PAD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            zrld_pkg::CSR_COMPRESSED_LENGTH: length_ff <= csr_data;
            zrld_pkg::CSR_PAD_ZERO_BYTES:    pad_ff    <= csr_data[zrld_pkg::BYTE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Decode state; a length write restarts the stream.
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff    <= zrld_pkg::PH_HEADER;
         high_ff     <= '0;
         lit_ff      <= '0;
         consumed_ff <= '0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         high_ff     <= high_in;
         lit_ff      <= lit_in;
         consumed_ff <= consumed_in;
      end
   end

   // Classify the incoming byte and build the queued action.
   always_comb begin
      phase_in    = phase_ff;
      high_in     = high_ff;
      lit_in      = lit_ff;
      consumed_in = consumed_ff;
      q_push      = 1'b0;
      q_entry.byte_value   = '0;
      q_entry.repeat_count = '0;
      q_entry.error_code   = zrld_pkg::ERR_NONE;
      q_entry.last         = 1'b0;
      q_entry.pad_follows  = 1'b0;
      q_entry.pad_count    = pad_ff;

      if (phase_ff == zrld_pkg::PH_DONE) begin
         // Finished stream: the byte is dropped.
      end else if (length_ff == '0) begin
         // Empty stream: only the pad result.
         q_push = 1'b1;
         q_entry.repeat_count = zrld_pkg::COUNT_BITS'(pad_ff);
         q_entry.last         = 1'b1;
         phase_in             = zrld_pkg::PH_DONE;
      end else begin
         consumed_in = pos;
         case (phase_ff)
            zrld_pkg::PH_HEADER: begin
               if (!req_tdata[7]) begin
                  q_push = 1'b1;
                  q_entry.repeat_count = zrld_pkg::COUNT_BITS'(req_tdata[6:0])
                                         + zrld_pkg::COUNT_BITS'(1);
               end else if (!req_tdata[6]) begin
                  if (pos == length_ff) begin
                     q_push = 1'b1;
                     q_entry.error_code = zrld_pkg::ERR_TRUNCATED;
                     q_entry.last       = 1'b1;
                     phase_in           = zrld_pkg::PH_DONE;
                  end else begin
                     high_in  = req_tdata[5:0];
                     phase_in = zrld_pkg::PH_EXTENDED;
                  end
               end else begin
                  if (lit_end > {1'b0, length_ff}) begin
                     q_push = 1'b1;
                     q_entry.error_code = zrld_pkg::ERR_OVERRUN;
                     q_entry.last       = 1'b1;
                     phase_in           = zrld_pkg::PH_DONE;
                  end else begin
                     lit_in   = lit_cnt;
                     phase_in = zrld_pkg::PH_LITERAL;
                  end
               end
            end
            zrld_pkg::PH_EXTENDED: begin
               q_push = 1'b1;
               q_entry.repeat_count = {1'b0, high_ff, req_tdata} + zrld_pkg::EXT_RUN_OFFSET;
               high_in  = '0;
               phase_in = zrld_pkg::PH_HEADER;
            end
            default: begin
               q_push = 1'b1;
               q_entry.byte_value   = req_tdata;
               q_entry.repeat_count = zrld_pkg::COUNT_BITS'(1);
               lit_in = lit_ff - 7'd1;
               if (lit_in == '0) begin
                  phase_in = zrld_pkg::PH_HEADER;
               end
            end
         endcase

         // Stream completes on this byte: a pad result closes it.
         if (pos == length_ff && phase_in != zrld_pkg::PH_DONE) begin
            if (q_push) begin
               q_entry.pad_follows = 1'b1;
            end else begin
               q_push = 1'b1;
               q_entry.repeat_count = zrld_pkg::COUNT_BITS'(pad_ff);
               q_entry.last         = 1'b1;
            end
            phase_in = zrld_pkg::PH_DONE;
         end
      end

      if (!accept) begin
         q_push = 1'b0;
      end
   end

endmodule

// ===== src/zrld_queue.sv =====
module zrld_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  zrld_pkg::entry_type push_entry,
   output logic                push_ready,
   input  logic                pop,
   output logic                head_valid,
   output zrld_pkg::entry_type head_entry
);

   zrld_pkg::entry_type                   mem_ff [zrld_pkg::QUEUE_DEPTH];
   logic [zrld_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [zrld_pkg::QUEUE_CNT_BITS-1:0]   count_ff, count_in;
   logic                                  do_push, do_pop;

   assign push_ready = (count_ff != zrld_pkg::QUEUE_CNT_BITS'(zrld_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];
   assign do_push    = push & push_ready;
   assign do_pop     = pop & head_valid;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + zrld_pkg::QUEUE_CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - zrld_pkg::QUEUE_CNT_BITS'(1);
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + zrld_pkg::QUEUE_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + zrld_pkg::QUEUE_PTR_BITS'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/zrld_back.sv =====
module zrld_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  zrld_pkg::entry_type head_entry,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser,
   output logic                rsp_tlast
);

   logic                                 valid_ff;
   logic [zrld_pkg::BYTE_BITS-1:0]       value_ff;
   logic [zrld_pkg::COUNT_BITS-1:0]      count_ff;
   logic [zrld_pkg::ERROR_BITS-1:0]      error_ff;
   logic                                 last_ff;
   logic                                 pad_pend_ff;
   logic [zrld_pkg::BYTE_BITS-1:0]       pad_count_ff;
   logic                                 free;

   // The output register can load when empty or when its beat leaves now.
   assign free = !valid_ff | rsp_tready;
   assign pop  = free & !pad_pend_ff & head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         pad_pend_ff <= 1'b0;
      end else if (free) begin
         if (pad_pend_ff) begin
            valid_ff    <= 1'b1;
            pad_pend_ff <= 1'b0;
         end else begin
            valid_ff    <= head_valid;
            pad_pend_ff <= head_valid & head_entry.pad_follows;
         end
      end
   end

   // Result payload: the queued first result, then the pad result if due.
   always_ff @(posedge clock) begin
      if (free) begin
         if (pad_pend_ff) begin
            value_ff <= '0;
            count_ff <= zrld_pkg::COUNT_BITS'(pad_count_ff);
            error_ff <= zrld_pkg::ERR_NONE;
            last_ff  <= 1'b1;
         end else if (head_valid) begin
            value_ff     <= head_entry.byte_value;
            count_ff     <= head_entry.repeat_count;
            error_ff     <= head_entry.error_code;
            last_ff      <= head_entry.last & !head_entry.pad_follows;
            pad_count_ff <= head_entry.pad_count;
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, count_ff, value_ff};
   assign rsp_tuser  = error_ff;
   assign rsp_tlast  = last_ff;

endmodule

// ===== src/zero_run_length_decoder.sv =====
// Channel   Direction  Beat contents
// req_      in         tdata[7:0] compressed_byte
// rsp_      out        tdata[7:0] byte_value, tdata[22:8] repeat_count; tuser error_code;
//                      tlast last
// csr_      in         index 0 compressed_length, index 1 pad_zero_bytes; data in csr_data
//
// One compressed byte is taken per cycle while the queue has room; the front end
// decodes it in that cycle. A byte that ends a non-empty stream without error yields
// two beats, its result and then the pad result; any other byte yields at most one.
// Synchronous reset clears the decode state, the queue and the output register.
// A two-entry queue parts decode from output, so a stalled rsp_ side stops req_
// only once the queue is full.
module zero_run_length_decoder (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,   // [7:0] compressed_byte
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [23:0]                          rsp_tdata,   // [7:0] byte_value, [22:8] repeat_count
   output logic [1:0]                           rsp_tuser,   // [1:0] error_code
   output logic                                 rsp_tlast,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [zrld_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [zrld_pkg::LENGTH_BITS-1:0]     csr_data
);

   logic                q_push, q_ready, q_pop, q_valid;
   zrld_pkg::entry_type q_entry, q_head;

   // Decode front end.
   zrld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_ready    (q_ready),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   // Action queue.
   zrld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .push_ready (q_ready),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_entry (q_head)
   );

   // Output back end.
   zrld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_entry (q_head),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
